@@ hw/rtl/srt_pkg.sv @@
`timescale 1ns / 1ps
package srt_pkg;
  localparam int unsigned SlotsDef = 16;
  localparam int unsigned IntervalBitsDef = 24;
  localparam int unsigned CfgW = 16;
  localparam logic [0:0] CfgIdxInterval = 1'b0;
  localparam logic [0:0] CfgIdxRetries = 1'b1;
  localparam logic [15:0] InitIntervalRst = 16'd500;
  localparam logic [3:0] MaxRetriesRst = 4'd6;

  localparam logic [1:0] ReqStart = 2'd0;
  localparam logic [1:0] ReqResponse = 2'd1;
  localparam logic [1:0] ReqTick = 2'd2;
  localparam logic [1:0] ReqCancel = 2'd3;

  localparam logic [2:0] EvStarted = 3'd0;
  localparam logic [2:0] EvFull = 3'd1;
  localparam logic [2:0] EvRetransmit = 3'd2;
  localparam logic [2:0] EvTimeout = 3'd3;
  localparam logic [2:0] EvMatched = 3'd4;
  localparam logic [2:0] EvUnmatched = 3'd5;
  localparam logic [2:0] EvCancelled = 3'd6;
endpackage

@@ hw/rtl/srt_ram.sv @@
`timescale 1ns / 1ps
module srt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ hw/rtl/stun_retransmit_table_top.sv @@
`timescale 1ns / 1ps
// Retransmission table for pending request transactions. A word is taken at a clock edge with
// start high and busy low: start (req 0), response (1), one-millisecond tick (2) or cancel-all
// (3). Results come out one per cycle on the res_* ports, marked by res_valid_o, with last_o on
// the final result of a word; the receiver cannot stall them, so they must be taken as shown.
// A start claims the lowest free slot straight from the valid flops: busy for one cycle. Response,
// tick and cancel-all sweep the slot memory once, one read a cycle through the single read port,
// then flush the last result in StDone before busy falls. Each result is held pending until a
// newer one replaces it or the word ends, so last can be set when known.
// Slot valid bits are flip-flops cleared at reset; slot payload lives in one RAM and is
// written only when a slot is claimed or updated.
module stun_retransmit_table_top #(
  parameter int unsigned SLOTS = srt_pkg::SlotsDef,
  parameter int unsigned INTERVAL_BITS = srt_pkg::IntervalBitsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              req_type_i,
  input  logic [31:0]             txn_id_hi_i,
  input  logic [63:0]             txn_id_lo_i,
  input  logic                    cfg_we_i,
  input  logic [0:0]              cfg_idx_i,
  input  logic [srt_pkg::CfgW-1:0] cfg_wdata_i,
  output logic                    res_valid_o,
  output logic [2:0]              event_res_o,
  output logic [3:0]              slot_o,
  output logic [31:0]             out_id_hi_o,
  output logic [63:0]             out_id_lo_o,
  output logic                    last_o
);
  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned IB = INTERVAL_BITS;
  // entry: id_hi, id_lo, countdown, interval, retries
  localparam int unsigned EW = 32 + 64 + IB + IB + 4;
  localparam logic [IB-1:0] IvMax = {IB{1'b1}};

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  logic [1:0]  state_q, state_d;
  logic [SW:0] cnt_q, cnt_d;          // read address in flight
  logic        rv_q;                  // a read datum arrives this cycle
  logic [SW-1:0] raddr_q;             // slot of the arriving datum
  logic [1:0]  kind_q;
  logic [31:0] hi_q;
  logic [63:0] lo_q;
  logic [SLOTS-1:0] valid_q, valid_d;
  logic        found_q, found_d;
  logic [15:0] init_iv_q;
  logic [3:0]  max_ret_q;

  // pending result, held until a newer one replaces it or the word ends, so last can be set when known
  logic        pend_q, pend_d;
  logic [2:0]  pev_q, pev_d;
  logic [SW-1:0] pslot_q, pslot_d;
  logic [31:0] phi_q, phi_d;
  logic [63:0] plo_q, plo_d;

  logic        we;
  logic [SW-1:0] waddr;
  logic [EW-1:0] wdata, rdata;
  logic [SW-1:0] raddr;

  srt_ram #(.Width(EW), .Depth(SLOTS)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata), .raddr_i(raddr), .rdata_o(rdata)
  );

  logic [31:0]   r_hi;
  logic [63:0]   r_lo;
  logic [IB-1:0] r_cd, r_iv, n_iv;
  logic [3:0]    r_rt;
  assign {r_hi, r_lo, r_cd, r_iv, r_rt} = rdata;
  assign n_iv = (r_iv > (IvMax >> 1)) ? IvMax : {r_iv[IB-2:0], 1'b0};
  assign raddr = cnt_q[SW-1:0];
  assign busy = (state_q != StIdle);

  logic emit; logic [2:0] ev; logic [SW-1:0] es; logic [31:0] ehi; logic [63:0] elo;
  logic free_slot_ok; logic [SW-1:0] free_slot;

  always_comb begin
    free_slot_ok = 1'b0;
    free_slot = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_slot_ok = 1'b1;
        free_slot = SW'(i);
      end
    end
  end

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; valid_d = valid_q; found_d = found_q;
    we = 1'b0; waddr = raddr_q; wdata = rdata;
    emit = 1'b0; ev = srt_pkg::EvStarted; es = raddr_q; ehi = r_hi; elo = r_lo;
    case (state_q)
      StIdle: begin
        cnt_d = '0; found_d = 1'b0;
        if (start) begin
          if (req_type_i == srt_pkg::ReqStart) begin
            // start claims at once; no sweep needed
            emit = 1'b1; ehi = txn_id_hi_i; elo = txn_id_lo_i;
            state_d = StDone;
            if (free_slot_ok) begin
              ev = srt_pkg::EvStarted; es = free_slot;
              valid_d[free_slot] = 1'b1;
              we = 1'b1; waddr = free_slot;
              wdata = {txn_id_hi_i, txn_id_lo_i, IB'(init_iv_q), IB'(init_iv_q), 4'd0};
            end else begin
              ev = srt_pkg::EvFull; es = '0;
            end
          end else begin
            state_d = StScan;
          end
        end
      end
      StScan: begin
        if (cnt_q < (SW+1)'(SLOTS)) cnt_d = cnt_q + 1'b1;
        else state_d = StDone;
        if (rv_q && valid_q[raddr_q]) begin
          case (kind_q)
            srt_pkg::ReqResponse: begin
              if (!found_q && r_hi == hi_q && r_lo == lo_q) begin
                found_d = 1'b1; valid_d[raddr_q] = 1'b0;
                emit = 1'b1; ev = srt_pkg::EvMatched; ehi = hi_q; elo = lo_q;
              end
            end
            srt_pkg::ReqTick: begin
              we = 1'b1;
              if (r_cd > IB'(1)) begin
                wdata = {r_hi, r_lo, r_cd - 1'b1, r_iv, r_rt};
              end else if (r_rt >= max_ret_q) begin
                valid_d[raddr_q] = 1'b0;
                emit = 1'b1; ev = srt_pkg::EvTimeout;
              end else begin
                wdata = {r_hi, r_lo, n_iv, n_iv, r_rt + 4'd1};
                emit = 1'b1; ev = srt_pkg::EvRetransmit;
              end
            end
            default: begin
              valid_d[raddr_q] = 1'b0;
              emit = 1'b1; ev = srt_pkg::EvCancelled;
            end
          endcase
        end
        if (state_d == StDone && kind_q == srt_pkg::ReqResponse && !found_d) begin
          emit = 1'b1; ev = srt_pkg::EvUnmatched; es = '0; ehi = hi_q; elo = lo_q;
        end
      end
      default: state_d = StIdle;  // StDone: flush pending result as last
    endcase
  end

  assign pend_d = emit ? 1'b1 : ((state_q == StDone) ? 1'b0 : pend_q);
  assign pev_d = emit ? ev : pev_q;
  assign pslot_d = emit ? es : pslot_q;
  assign phi_d = emit ? ehi : phi_q;
  assign plo_d = emit ? elo : plo_q;

  // a pending result is shown when a newer one replaces it or the word ends
  assign res_valid_o = pend_q && (emit || state_q == StDone);
  assign last_o = (state_q == StDone);
  assign event_res_o = pev_q;
  assign slot_o = 4'(pslot_q);
  assign out_id_hi_o = phi_q;
  assign out_id_lo_o = plo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; cnt_q <= '0; rv_q <= 1'b0; valid_q <= '0; found_q <= 1'b0;
      pend_q <= 1'b0; init_iv_q <= srt_pkg::InitIntervalRst; max_ret_q <= srt_pkg::MaxRetriesRst;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; valid_q <= valid_d; found_q <= found_d;
      pend_q <= pend_d;
      rv_q <= (state_q == StScan) && (cnt_q < (SW+1)'(SLOTS));
      if (cfg_we_i && cfg_idx_i == srt_pkg::CfgIdxInterval) init_iv_q <= cfg_wdata_i;
      if (cfg_we_i && cfg_idx_i == srt_pkg::CfgIdxRetries) max_ret_q <= cfg_wdata_i[3:0];
    end
  end

  always_ff @(posedge clk_i) begin
    raddr_q <= raddr;
    pev_q <= pev_d; pslot_q <= pslot_d; phi_q <= phi_d; plo_q <= plo_d;
    if (start && !busy) begin
      kind_q <= req_type_i; hi_q <= txn_id_hi_i; lo_q <= txn_id_lo_i;
    end
  end

  a_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o && pend_q |-> res_valid_o) else $error("last result dropped");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StDone |=> state_q == StIdle) else $error("done not followed by idle");
  a_no_res_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StIdle |-> !res_valid_o) else $error("result while idle");
endmodule
